/* src/tfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt fall detector package
// Shared constants, register codes, command and status types for the tilt
// fall detector.
// ----------------------------------------------------------------------------
package tfd_pkg;

    // Smoothing weight is unsigned Q0.16.
    localparam int WEIGHT_W    = 16;
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_HALF = 32768;

    localparam int THRESH_W    = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd58982;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd722500;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_THRESHOLD   = 1'd1;

    typedef enum logic [1:0] {
        KIND_SIDE  = 2'd0,
        KIND_BACK  = 2'd1,
        KIND_FRONT = 2'd2
    } fall_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_BACK,
        ST_UPD_BACK,
        ST_MUL_SIDE,
        ST_UPD_SIDE,
        ST_SQ_BACK,
        ST_SQ_SIDE,
        ST_DECIDE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic mul_back;
        logic upd_back;
        logic mul_side;
        logic upd_side;
        logic sq_back;
        logic sq_side;
        logic decide;
        logic load_out;
    } tfd_cmd_t;

    typedef struct packed {
        logic req_getup;
    } tfd_status_t;

endpackage
`default_nettype wire

/* src/tfd_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one sensor update or getup-complete event.
// ----------------------------------------------------------------------------
interface tfd_req_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic signed [SAMPLE_WIDTH-1:0] accel_back;
    logic signed [SAMPLE_WIDTH-1:0] accel_side;

    modport source (output valid, req_type, accel_back, accel_side, input ready);
    modport sink   (input valid, req_type, accel_back, accel_side, output ready);
endinterface
`default_nettype wire

/* src/tfd_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one detector result per request.
// ----------------------------------------------------------------------------
interface tfd_res_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           fall_start;
    logic [1:0]                     fall_kind;
    logic                           pending;
    logic signed [SAMPLE_WIDTH-1:0] back_average;
    logic signed [SAMPLE_WIDTH-1:0] side_average;

    modport source (output valid, fall_start, fall_kind, pending, back_average,
                    side_average, input ready);
    modport sink   (input valid, fall_start, fall_kind, pending, back_average,
                    side_average, output ready);
endinterface
`default_nettype wire

/* src/tfd_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel with register index and write data.
// ----------------------------------------------------------------------------
interface tfd_cfg_if;
    import tfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/tilt_fall_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt fall detector
// Smooths two accelerometer axes, flags a fall when the squared magnitude of
// the averages exceeds a threshold and classifies it as side, back or front.
//
//   Channel  Direction  Beat contents
//   req      in         req_type, accel_back, accel_side
//   res      out        fall_start, fall_kind, pending, back_average,
//                       side_average
//   cfg      in         index, data (register write)
//
// A sensor update steps the shared multiplier through two filter products
// and two squares, then decides and loads the result register; the next
// request can be taken in the same cycle as the result is offered. A
// getup-complete event loads its result directly after accept. One request
// is in work at a time. The result register holds a beat while the next
// request is accepted; work stalls in its last step only if the previous
// result is still unread. Reset loads the default weight and threshold and
// clears the averages.
// ----------------------------------------------------------------------------
module tilt_fall_detector #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 8
) (
    input  wire      clk,
    input  wire      rst_n,
    tfd_req_if.sink  req,
    tfd_res_if.source res,
    tfd_cfg_if.sink  cfg
);
    import tfd_pkg::*;

    tfd_cmd_t    cmd;
    tfd_status_t status;

    assign cfg.ready = 1'b1;

    tfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tfd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_req_type   (req.req_type),
        .in_accel_back (req.accel_back),
        .in_accel_side (req.accel_side),
        .cfg_wr        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .fall_start    (res.fall_start),
        .fall_kind     (res.fall_kind),
        .pending       (res.pending),
        .back_average  (res.back_average),
        .side_average  (res.side_average)
    );

endmodule
`default_nettype wire

/* src/tfd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt fall detector datapath
// Configuration registers, filter state, one shared multiplier, threshold
// compare, classification and the result register.
// ----------------------------------------------------------------------------
module tfd_datapath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  tfd_pkg::tfd_cmd_t                 cmd,
    output tfd_pkg::tfd_status_t              status,
    input  wire                               in_req_type,
    input  wire signed [SAMPLE_WIDTH-1:0]     in_accel_back,
    input  wire signed [SAMPLE_WIDTH-1:0]     in_accel_side,
    input  wire                               cfg_wr,
    input  wire [tfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [tfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                              fall_start,
    output logic [1:0]                        fall_kind,
    output logic                              pending,
    output logic signed [SAMPLE_WIDTH-1:0]    back_average,
    output logic signed [SAMPLE_WIDTH-1:0]    side_average
);
    import tfd_pkg::*;

    localparam int ACC_W = SAMPLE_WIDTH + FRAC_BITS;
    localparam int AW    = ACC_W + 1;
    localparam int BW    = (SAMPLE_WIDTH > WEIGHT_W + 1) ? SAMPLE_WIDTH : WEIGHT_W + 1;
    localparam int PW    = AW + BW;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH;
    localparam int CW    = (SQ_W > THRESH_W) ? SQ_W : THRESH_W;
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'(WEIGHT_HALF);

    logic [WEIGHT_W-1:0]            weight_reg;
    logic [THRESH_W-1:0]            threshold_reg;
    logic signed [ACC_W-1:0]        back_filter_reg;
    logic signed [ACC_W-1:0]        side_filter_reg;
    logic                           pending_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_back_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_side_reg;
    logic signed [PW-1:0]           product_reg;
    logic [SQ_W-1:0]                sq_back_reg;
    logic                           start_reg;
    fall_kind_t                     kind_reg;
    logic                           out_start_reg;
    fall_kind_t                     out_kind_reg;
    logic                           out_pending_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_back_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_side_reg;

    logic signed [ACC_W-1:0]        scaled_back;
    logic signed [ACC_W-1:0]        scaled_side;
    logic signed [AW-1:0]           diff_back;
    logic signed [AW-1:0]           diff_side;
    logic signed [SAMPLE_WIDTH-1:0] back_int;
    logic signed [SAMPLE_WIDTH-1:0] side_int;
    logic signed [AW-1:0]           mul_a;
    logic signed [BW-1:0]           mul_b;
    logic signed [PW-1:0]           mul_full;
    logic signed [PW-1:0]           rounded;
    logic signed [ACC_W-1:0]        back_filter_next;
    logic signed [ACC_W-1:0]        side_filter_next;
    logic [CW-1:0]                  magnitude;
    logic [ACC_W-1:0]               abs_back;
    logic [ACC_W-1:0]               abs_side;
    logic                           mul_en;
    logic                           fall_hit;
    fall_kind_t                     kind_next;

    assign status.req_getup = in_req_type;

    // With acc = w*old + (1-w)*scaled, the new average is scaled plus the
    // rounded high part of (old - scaled)*w, so one multiply per axis.
    assign scaled_back = ACC_W'(sample_back_reg) <<< FRAC_BITS;
    assign scaled_side = ACC_W'(sample_side_reg) <<< FRAC_BITS;
    assign diff_back   = AW'(back_filter_reg) - AW'(scaled_back);
    assign diff_side   = AW'(side_filter_reg) - AW'(scaled_side);
    assign back_int    = back_filter_reg[ACC_W-1:FRAC_BITS];
    assign side_int    = side_filter_reg[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_back)
        begin
            mul_a = diff_back;
            mul_b = BW'(signed'({1'b0, weight_reg}));
        end
        else if (cmd.mul_side)
        begin
            mul_a = diff_side;
            mul_b = BW'(signed'({1'b0, weight_reg}));
        end
        else if (cmd.sq_back)
        begin
            mul_a = AW'(back_int);
            mul_b = BW'(back_int);
        end
        else if (cmd.sq_side)
        begin
            mul_a = AW'(side_int);
            mul_b = BW'(side_int);
        end
    end

    assign mul_full = mul_a * mul_b;
    assign mul_en   = cmd.mul_back | cmd.mul_side | cmd.sq_back | cmd.sq_side;

    assign rounded          = (product_reg + ROUND_BIAS) >>> WEIGHT_FRAC;
    assign back_filter_next = scaled_back + ACC_W'(rounded);
    assign side_filter_next = scaled_side + ACC_W'(rounded);

    // The side square sits in product_reg while the back square waits.
    assign magnitude = CW'(sq_back_reg) + CW'(product_reg[SQ_W-1:0]);
    assign fall_hit  = !pending_reg && (magnitude > CW'(threshold_reg));

    assign abs_back = back_filter_reg[ACC_W-1] ? ACC_W'(-back_filter_reg)
                                               : ACC_W'(back_filter_reg);
    assign abs_side = side_filter_reg[ACC_W-1] ? ACC_W'(-side_filter_reg)
                                               : ACC_W'(side_filter_reg);

    always_comb
    begin
        if (abs_back < abs_side)
            kind_next = KIND_SIDE;
        else if (back_filter_reg[ACC_W-1])
            kind_next = KIND_BACK;
        else
            kind_next = KIND_FRONT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg      <= WEIGHT_RESET;
            threshold_reg   <= THRESH_RESET;
            back_filter_reg <= '0;
            side_filter_reg <= '0;
            pending_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_SMOOTHING_WEIGHT: weight_reg    <= cfg_data[WEIGHT_W-1:0];
                    REG_FALL_THRESHOLD:   threshold_reg <= cfg_data[THRESH_W-1:0];
                endcase
            end
            if (cmd.upd_back)
                back_filter_reg <= back_filter_next;
            if (cmd.upd_side)
                side_filter_reg <= side_filter_next;
            if (cmd.capture && in_req_type)
                pending_reg <= 1'b0;
            else if (cmd.decide && fall_hit)
                pending_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_back_reg <= in_accel_back;
            sample_side_reg <= in_accel_side;
            start_reg       <= 1'b0;
            kind_reg        <= KIND_SIDE;
        end
        if (mul_en)
            product_reg <= mul_full;
        if (cmd.sq_side)
            sq_back_reg <= product_reg[SQ_W-1:0];
        if (cmd.decide && fall_hit)
        begin
            start_reg <= 1'b1;
            kind_reg  <= kind_next;
        end
        if (cmd.load_out)
        begin
            out_start_reg   <= start_reg;
            out_kind_reg    <= kind_reg;
            out_pending_reg <= pending_reg;
            out_back_reg    <= back_int;
            out_side_reg    <= side_int;
        end
    end

    assign fall_start   = out_start_reg;
    assign fall_kind    = out_kind_reg;
    assign pending      = out_pending_reg;
    assign back_average = out_back_reg;
    assign side_average = out_side_reg;

endmodule
`default_nettype wire

/* src/tfd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt fall detector controller
// Sequences the shared multiplier through the filter update, the squares and
// the decision, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module tfd_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  tfd_pkg::tfd_status_t  status,
    output tfd_pkg::tfd_cmd_t     cmd
);
    import tfd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.req_getup ? ST_DONE : ST_MUL_BACK;
                end
            end
            ST_MUL_BACK:
            begin
                cmd.mul_back = 1'b1;
                state_next   = ST_UPD_BACK;
            end
            ST_UPD_BACK:
            begin
                cmd.upd_back = 1'b1;
                state_next   = ST_MUL_SIDE;
            end
            ST_MUL_SIDE:
            begin
                cmd.mul_side = 1'b1;
                state_next   = ST_UPD_SIDE;
            end
            ST_UPD_SIDE:
            begin
                cmd.upd_side = 1'b1;
                state_next   = ST_SQ_BACK;
            end
            ST_SQ_BACK:
            begin
                cmd.sq_back = 1'b1;
                state_next  = ST_SQ_SIDE;
            end
            ST_SQ_SIDE:
            begin
                cmd.sq_side = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here only while the previous result is still unread.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* src/tfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt fall detector checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       req_valid,
    input wire       req_ready,
    input wire       res_valid,
    input wire       res_ready,
    input wire       fall_start,
    input wire [1:0] fall_kind,
    input wire       pending
);
    import tfd_pkg::*;

    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;
    logic       req_beat;
    logic       res_beat;

    assign req_beat = req_valid && req_ready;
    assign res_beat = res_valid && res_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (req_beat && !res_beat)
            outstanding_next = outstanding_reg + 2'd1;
        else if (res_beat && !req_beat)
            outstanding_next = outstanding_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= 2'd0;
        else
            outstanding_reg <= outstanding_next;
    end

    // A result beat must answer a request that has not been answered yet.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (outstanding_reg != 2'd0))
        else $error("result offered with no request outstanding");

    // A detected fall always leaves the detector waiting for getup.
    a_fall_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && fall_start) |-> pending)
        else $error("fall reported without pending mark");

    a_kind_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !fall_start) |-> (fall_kind == KIND_SIDE))
        else $error("fall kind set without a fall");

    a_res_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result valid dropped before the beat was taken");

endmodule

bind tilt_fall_detector tfd_checker u_tfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .fall_start (res.fall_start),
    .fall_kind  (res.fall_kind),
    .pending    (res.pending)
);
`default_nettype wire
